// File: rtl/core/ttes_pkg.sv
// Shared types, constants and arithmetic helpers for the tile energy sum block.
`default_nettype none

package ttes_pkg;

    // Key decode divisors
    localparam int ARM_DIV  = 100000;
    localparam int SECT_DIV = 10000;
    localparam int ROW_DIV  = 100;

    // Reciprocal multiply: exact floor(x/d) for x below 2**n with shift n+ceil(log2 d)
    localparam int ARM_SHIFT  = 37;
    localparam int SECT_SHIFT = 31;
    localparam int ROW_SHIFT  = 21;

    localparam longint ARM_RECIP  = ((longint'(1) << ARM_SHIFT) + ARM_DIV - 1) / ARM_DIV;
    localparam longint SECT_RECIP = ((longint'(1) << SECT_SHIFT) + SECT_DIV - 1) / SECT_DIV;
    localparam longint ROW_RECIP  = ((longint'(1) << ROW_SHIFT) + ROW_DIV - 1) / ROW_DIV;

    // Configuration register indexes
    localparam logic [7:0] CFG_ARM      = 8'd0;
    localparam logic [7:0] CFG_SECTOR   = 8'd1;
    localparam logic [7:0] CFG_CENTER_Z = 8'd2;
    localparam logic [7:0] CFG_CENTER_Y = 8'd3;

    // Accumulator select bits
    localparam int SEL_PART = 0;
    localparam int SEL_TILE = 1;
    localparam int SEL_WIN  = 2;
    localparam int NUM_WIN  = 4;
    localparam int NUM_SEL  = SEL_WIN + NUM_WIN;

    localparam logic signed [31:0] ENERGY_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] ENERGY_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [19:0]        key;
        logic [31:0]        cum;
        logic [31:0]        prev;
        logic               has_prev;
        logic               last;
        logic               zero;
        logic [3:0]         arm;
        logic [3:0]         sect;
        logic [16:0]        rest;
        logic [6:0]         yv;
        logic [6:0]         zv;
        logic [31:0]        energy;
        logic               eclip;
        logic [NUM_SEL-1:0] sel;
    } stage_t;

    // {clip, value}
    function automatic logic [32:0] clamp33(input logic signed [32:0] v);
        logic [32:0] r;
        if (v[32] != v[31])
        begin
            r = {1'b1, (v[32] ? ENERGY_MIN : ENERGY_MAX)};
        end
        else
        begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    function automatic logic [32:0] sat_add(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return clamp33(s);
    endfunction

    function automatic logic in_span(input logic signed [8:0] d,
                                     input logic signed [8:0] lo,
                                     input logic signed [8:0] size);
        return (d >= lo) && (d < lo + size);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/trigger_tile_energy_sum.sv
// Cluster tile energy sums: tower key decode, sector/tile/window accumulation, result output.
// Throughput: one tower item per cycle through an 8-stage decode pipeline and one
// accumulator stage; s_tready drops only while a result and a following last item back up.
// Reset (rst_n low, async) clears configuration registers, all sums, the stop and clip
// flags, and every pipeline valid bit. No clearing pass is needed.
`default_nettype none

module trigger_tile_energy_sum
    import ttes_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // tower items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,   // tower_key[19:0], cum_energy[51:20], prev_cum_energy[83:52]
    input  wire logic [0:0]  s_tuser,   // has_previous[0]
    input  wire logic        s_tlast,   // last_tower
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // part_energy[31:0], energy_2x2[63:32], energy_4x4[95:64]
    output logic [0:0]       m_tuser    // saturated[0]
);

    localparam int NSTG = 8;

    // configuration
    logic [3:0] cfg_arm_reg;
    logic [3:0] cfg_sect_reg;
    logic [6:0] cfg_cz_reg;
    logic [6:0] cfg_cy_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_arm_reg  <= '0;
            cfg_sect_reg <= '0;
            cfg_cz_reg   <= '0;
            cfg_cy_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ARM:      cfg_arm_reg  <= cfg_data[3:0];
                CFG_SECTOR:   cfg_sect_reg <= cfg_data[3:0];
                CFG_CENTER_Z: cfg_cz_reg   <= cfg_data[6:0];
                CFG_CENTER_Y: cfg_cy_reg   <= cfg_data[6:0];
                default:      ;
            endcase
        end
    end

    // pipeline
    stage_t            stg_in;
    stage_t            stg_reg  [1:NSTG];
    stage_t            stg_next [2:NSTG];
    logic [NSTG:1]     vld_reg;
    logic [NSTG:1]     take;
    logic              pass_last;
    logic              go_acc;
    logic              take_fin;
    logic              take_out;

    // accumulators and result stages
    logic signed [31:0] sum_part_reg, sum_part_next, part_upd;
    logic signed [31:0] sum_tile_reg, sum_tile_next, tile_upd;
    logic signed [31:0] sum_w_reg  [NUM_WIN];
    logic signed [31:0] sum_w_next [NUM_WIN];
    logic signed [31:0] w_upd      [NUM_WIN];
    logic               stop_reg, stop_next, stop_upd;
    logic               clip_reg, clip_next, clip_upd;
    logic [32:0]        add_part, add_tile;
    logic [32:0]        add_w [NUM_WIN];

    logic               fin_v_reg;
    logic signed [31:0] fin_part_reg;
    logic signed [31:0] fin_tile_reg;
    logic signed [31:0] fin_w_reg [NUM_WIN];
    logic               fin_clip_reg;

    logic               out_v_reg;
    logic [95:0]        out_data_reg;
    logic               out_sat_reg;
    logic signed [31:0] max_a, max_b, max_w;

    // flow control
    assign take_out  = !out_v_reg || m_tready;
    assign take_fin  = !fin_v_reg || take_out;
    assign pass_last = !stg_reg[NSTG].last || take_fin;
    assign go_acc    = vld_reg[NSTG] && pass_last;

    always_comb
    begin
        take[NSTG] = !vld_reg[NSTG] || pass_last;
        for (int k = NSTG - 1; k >= 1; k--)
        begin
            take[k] = !vld_reg[k] || take[k + 1];
        end
    end

    assign s_tready = take[1];

    // input item unpack
    always_comb
    begin
        stg_in          = '0;
        stg_in.key      = s_tdata[19:0];
        stg_in.cum      = s_tdata[51:20];
        stg_in.prev     = s_tdata[83:52];
        stg_in.has_prev = s_tuser[0];
        stg_in.last     = s_tlast;
    end

    // stage logic
    logic [40:0]        arm_prod;
    logic [34:0]        sect_prod;
    logic [28:0]        row_prod;
    logic signed [32:0] ediff;
    logic [32:0]        eclamp;
    logic signed [8:0]  dz, dy;
    logic               hit;

    always_comb
    begin
        // stage 2: arm and tower energy
        stg_next[2]      = stg_reg[1];
        stg_next[2].zero = (stg_reg[1].key == '0);
        arm_prod         = 41'(stg_reg[1].key) * 41'(ARM_RECIP);
        stg_next[2].arm  = arm_prod[ARM_SHIFT + 3:ARM_SHIFT];
        ediff            = $signed({stg_reg[1].cum[31], stg_reg[1].cum})
                         - $signed({stg_reg[1].prev[31], stg_reg[1].prev});
        eclamp           = clamp33(ediff);
        if (stg_reg[1].has_prev && !stg_reg[1].cum[31] && (stg_reg[1].cum != '0))
        begin
            stg_next[2].energy = eclamp[31:0];
            stg_next[2].eclip  = eclamp[32];
        end
        else
        begin
            stg_next[2].energy = stg_reg[1].cum;
            stg_next[2].eclip  = 1'b0;
        end

        // stage 3: remainder after arm
        stg_next[3]      = stg_reg[2];
        stg_next[3].rest = 17'(stg_reg[2].key - 20'(stg_reg[2].arm) * 20'(ARM_DIV));

        // stage 4: sector
        stg_next[4]      = stg_reg[3];
        sect_prod        = 35'(stg_reg[3].rest) * 35'(SECT_RECIP);
        stg_next[4].sect = sect_prod[SECT_SHIFT + 3:SECT_SHIFT];

        // stage 5: remainder after sector
        stg_next[5]      = stg_reg[4];
        stg_next[5].rest = stg_reg[4].rest - 17'(stg_reg[4].sect) * 17'(SECT_DIV);

        // stage 6: y
        stg_next[6]      = stg_reg[5];
        row_prod         = 29'(stg_reg[5].rest[13:0]) * 29'(ROW_RECIP);
        stg_next[6].yv   = row_prod[ROW_SHIFT + 6:ROW_SHIFT];

        // stage 7: z
        stg_next[7]      = stg_reg[6];
        stg_next[7].zv   = 7'(stg_reg[6].rest - 17'(stg_reg[6].yv) * 17'(ROW_DIV));

        // stage 8: sector match and box selects, relative to the aligned tile corner
        stg_next[8]      = stg_reg[7];
        hit              = !stg_reg[7].zero && (stg_reg[7].arm == cfg_arm_reg)
                         && (stg_reg[7].sect == cfg_sect_reg);
        dz               = $signed({2'b00, stg_reg[7].zv}) - $signed({2'b00, cfg_cz_reg & 7'h7e});
        dy               = $signed({2'b00, stg_reg[7].yv}) - $signed({2'b00, cfg_cy_reg & 7'h7e});
        stg_next[8].sel[SEL_PART]    = hit;
        stg_next[8].sel[SEL_TILE]    = hit && in_span(dz, 9'sd0, 9'sd2)
                                           && in_span(dy, 9'sd0, 9'sd2);
        stg_next[8].sel[SEL_WIN + 0] = hit && in_span(dz, 9'sd0, 9'sd4)
                                           && in_span(dy, 9'sd0, 9'sd4);
        stg_next[8].sel[SEL_WIN + 1] = hit && in_span(dz, -9'sd2, 9'sd4)
                                           && in_span(dy, 9'sd0, 9'sd4);
        stg_next[8].sel[SEL_WIN + 2] = hit && in_span(dz, 9'sd0, 9'sd4)
                                           && in_span(dy, -9'sd2, 9'sd4);
        stg_next[8].sel[SEL_WIN + 3] = hit && in_span(dz, -9'sd2, 9'sd4)
                                           && in_span(dy, -9'sd2, 9'sd4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (take[1])
            begin
                vld_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= NSTG; k++)
            begin
                if (take[k])
                begin
                    vld_reg[k] <= vld_reg[k - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take[1])
        begin
            stg_reg[1] <= stg_in;
        end
        for (int k = 2; k <= NSTG; k++)
        begin
            if (take[k])
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    // accumulation
    always_comb
    begin
        add_part = sat_add(sum_part_reg, stg_reg[NSTG].energy);
        add_tile = sat_add(sum_tile_reg, stg_reg[NSTG].energy);
        for (int i = 0; i < NUM_WIN; i++)
        begin
            add_w[i] = sat_add(sum_w_reg[i], stg_reg[NSTG].energy);
        end

        part_upd = sum_part_reg;
        tile_upd = sum_tile_reg;
        for (int i = 0; i < NUM_WIN; i++)
        begin
            w_upd[i] = sum_w_reg[i];
        end
        stop_upd = stop_reg;
        clip_upd = clip_reg;

        if (go_acc && !stop_reg)
        begin
            if (stg_reg[NSTG].zero)
            begin
                stop_upd = 1'b1;
            end
            else
            begin
                clip_upd = clip_reg | stg_reg[NSTG].eclip;
                if (stg_reg[NSTG].sel[SEL_PART])
                begin
                    part_upd = add_part[31:0];
                    clip_upd = clip_upd | add_part[32];
                end
                if (stg_reg[NSTG].sel[SEL_TILE])
                begin
                    tile_upd = add_tile[31:0];
                    clip_upd = clip_upd | add_tile[32];
                end
                for (int i = 0; i < NUM_WIN; i++)
                begin
                    if (stg_reg[NSTG].sel[SEL_WIN + i])
                    begin
                        w_upd[i] = add_w[i][31:0];
                        clip_upd = clip_upd | add_w[i][32];
                    end
                end
            end
        end

        if (go_acc && stg_reg[NSTG].last)
        begin
            sum_part_next = '0;
            sum_tile_next = '0;
            for (int i = 0; i < NUM_WIN; i++)
            begin
                sum_w_next[i] = '0;
            end
            stop_next = 1'b0;
            clip_next = 1'b0;
        end
        else
        begin
            sum_part_next = part_upd;
            sum_tile_next = tile_upd;
            for (int i = 0; i < NUM_WIN; i++)
            begin
                sum_w_next[i] = w_upd[i];
            end
            stop_next = stop_upd;
            clip_next = clip_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_part_reg <= '0;
            sum_tile_reg <= '0;
            for (int i = 0; i < NUM_WIN; i++)
            begin
                sum_w_reg[i] <= '0;
            end
            stop_reg  <= 1'b0;
            clip_reg  <= 1'b0;
            fin_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            sum_part_reg <= sum_part_next;
            sum_tile_reg <= sum_tile_next;
            for (int i = 0; i < NUM_WIN; i++)
            begin
                sum_w_reg[i] <= sum_w_next[i];
            end
            stop_reg <= stop_next;
            clip_reg <= clip_next;
            if (take_fin)
            begin
                fin_v_reg <= go_acc && stg_reg[NSTG].last;
            end
            if (take_out)
            begin
                out_v_reg <= fin_v_reg;
            end
        end
    end

    // final sums and output register
    always_comb
    begin
        max_a = (fin_w_reg[0] > fin_w_reg[1]) ? fin_w_reg[0] : fin_w_reg[1];
        max_b = (fin_w_reg[2] > fin_w_reg[3]) ? fin_w_reg[2] : fin_w_reg[3];
        max_w = (max_a > max_b) ? max_a : max_b;
    end

    always_ff @(posedge clk)
    begin
        if (take_fin && go_acc && stg_reg[NSTG].last)
        begin
            fin_part_reg <= part_upd;
            fin_tile_reg <= tile_upd;
            for (int i = 0; i < NUM_WIN; i++)
            begin
                fin_w_reg[i] <= w_upd[i];
            end
            fin_clip_reg <= clip_upd;
        end
        if (take_out && fin_v_reg)
        begin
            out_data_reg <= {max_w, fin_tile_reg, fin_part_reg};
            out_sat_reg  <= fin_clip_reg;
        end
    end

    assign m_tvalid   = out_v_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_sat_reg;

`ifndef SYNTHESIS
    a_sums_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        go_acc && stg_reg[NSTG].last |=> (sum_part_reg == '0) && (sum_tile_reg == '0)
                                          && !stop_reg && !clip_reg)
        else $error("sums not cleared after last tower");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fin_v_reg && !take_out |=> fin_v_reg && $stable(fin_part_reg) && $stable(fin_clip_reg))
        else $error("pending result lost while output stalled");

    a_max_window: assert property (@(posedge clk) disable iff (!rst_n)
        fin_v_reg && take_out |=>
            ($signed(out_data_reg[95:64]) >= $past(fin_w_reg[0]))
            && ($signed(out_data_reg[95:64]) >= $past(fin_w_reg[1]))
            && ($signed(out_data_reg[95:64]) >= $past(fin_w_reg[2]))
            && ($signed(out_data_reg[95:64]) >= $past(fin_w_reg[3])))
        else $error("4x4 result below a window sum");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> vld_reg[NSTG] && stg_reg[NSTG].last && fin_v_reg)
        else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire
